### hw/rtl/ldag_pkg.sv
// Package with the constants, types and register indexes of the dissolve address generator.
`timescale 1ns / 1ps
`default_nettype none

package ldag_pkg;

    localparam int PITCH_LOG2 = 10;
    localparam int ADDR_BITS  = 20;

    localparam int LFSR_W   = 17;
    localparam int X_W      = 9;
    localparam int Y_W      = 8;
    localparam int OFFSET_W = Y_W + PITCH_LOG2 + 1;
    localparam int SUM_W    = ((ADDR_BITS > OFFSET_W) ? ADDR_BITS : OFFSET_W) + 1;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = ADDR_BITS;

    localparam logic [LFSR_W-1:0] LFSR_SEED = LFSR_W'(1);
    localparam logic [LFSR_W-1:0] LFSR_TAPS = LFSR_W'(17'h12000);

    localparam logic [X_W-1:0] AREA_WIDTH_RESET  = X_W'(319);
    localparam logic [Y_W-1:0] AREA_HEIGHT_RESET = Y_W'(199);

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_BASE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_BASE   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_AREA_WIDTH  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_AREA_HEIGHT = CFG_INDEX_W'(3);

    typedef struct packed {
        logic [LFSR_W-1:0] shift_register;
        logic              finished;
    } lfsr_state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] source_base;
        logic [ADDR_BITS-1:0] dest_base;
        logic [X_W-1:0]       area_width;
        logic [Y_W-1:0]       area_height;
    } area_cfg_t;

    typedef struct packed {
        logic                 copy_valid;
        logic [ADDR_BITS-1:0] read_address;
        logic [ADDR_BITS-1:0] write_address;
        logic                 sequence_done;
    } copy_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/ldag_step.sv
// One LFSR step: coordinate split, area test, address sums and next sequence state.
`timescale 1ns / 1ps
`default_nettype none

module ldag_step (
    input  wire logic                 start_over,
    input  wire ldag_pkg::lfsr_state_t state_cur,
    input  wire ldag_pkg::area_cfg_t   cfg,
    output ldag_pkg::lfsr_state_t      state_next,
    output ldag_pkg::copy_cmd_t        cmd
);

    logic [ldag_pkg::LFSR_W-1:0]   sr_cur;
    logic                          fin_cur;
    logic [ldag_pkg::LFSR_W-1:0]   sr_adv;
    logic [ldag_pkg::X_W-1:0]      x;
    logic [ldag_pkg::Y_W-1:0]      y;
    logic                          in_area;
    logic [ldag_pkg::OFFSET_W-1:0] offset;
    logic [ldag_pkg::SUM_W-1:0]    read_sum;
    logic [ldag_pkg::SUM_W-1:0]    write_sum;

    assign sr_cur  = start_over ? ldag_pkg::LFSR_SEED : state_cur.shift_register;
    assign fin_cur = start_over ? 1'b0 : state_cur.finished;

    assign x = sr_cur[ldag_pkg::LFSR_W-1:ldag_pkg::Y_W];
    assign y = sr_cur[ldag_pkg::Y_W-1:0];

    assign sr_adv = {1'b0, sr_cur[ldag_pkg::LFSR_W-1:1]}
                    ^ (sr_cur[0] ? ldag_pkg::LFSR_TAPS : '0);

    assign in_area = (x <= cfg.area_width) && (y <= cfg.area_height);

    assign offset = (ldag_pkg::OFFSET_W'(y) << ldag_pkg::PITCH_LOG2)
                    + ldag_pkg::OFFSET_W'(x);

    assign read_sum  = ldag_pkg::SUM_W'(cfg.source_base) + ldag_pkg::SUM_W'(offset);
    assign write_sum = ldag_pkg::SUM_W'(cfg.dest_base) + ldag_pkg::SUM_W'(offset);

    always_comb begin
        state_next.shift_register = sr_cur;
        state_next.finished       = fin_cur;
        cmd.copy_valid            = 1'b0;
        cmd.read_address          = '0;
        cmd.write_address         = '0;
        if (!fin_cur) begin
            state_next.shift_register = sr_adv;
            if (in_area) begin
                cmd.copy_valid      = 1'b1;
                cmd.read_address    = read_sum[ldag_pkg::ADDR_BITS-1:0];
                cmd.write_address   = write_sum[ldag_pkg::ADDR_BITS-1:0];
                state_next.finished = (sr_adv == ldag_pkg::LFSR_SEED);
            end
        end
        cmd.sequence_done = state_next.finished;
    end

endmodule

`default_nettype wire

### hw/rtl/lfsr_dissolve_address_generator.sv
// Top level of the pixel-dissolve address generator: config registers, LFSR state, output skid.
//
//   Channel  Direction  Handshake             Payload
//   s_       in         s_valid / s_ready     s_start_over
//   m_       out        m_valid / m_ready     m_copy_valid, m_read_address,
//                                             m_write_address, m_sequence_done
//   cfg_     in         cfg_we (no wait)      cfg_index, cfg_wdata
//
// Each accepted beat yields exactly one result beat, registered in the output register, or in
// the skid register while the output is stalled; a new beat can be accepted every cycle while
// the skid register is empty. The LFSR step and the two address adds are combinational, ahead
// of the output register. A two-entry output buffer (output register plus skid register) keeps
// input acceptance going for one more beat while the output is stalled. Reset seeds the LFSR
// with one, clears the done flag and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module lfsr_dissolve_address_generator (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_start_over,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_copy_valid,
    output logic [ldag_pkg::ADDR_BITS-1:0]         m_read_address,
    output logic [ldag_pkg::ADDR_BITS-1:0]         m_write_address,
    output logic                                   m_sequence_done,

    input  wire logic                              cfg_we,
    input  wire logic [ldag_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ldag_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    ldag_pkg::area_cfg_t   cfg_reg;
    ldag_pkg::lfsr_state_t state_reg;
    ldag_pkg::lfsr_state_t state_next;
    ldag_pkg::copy_cmd_t   cmd_next;
    ldag_pkg::copy_cmd_t   out_reg;
    ldag_pkg::copy_cmd_t   skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  s_accept;

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    ldag_step u_step (
        .start_over (s_start_over),
        .state_cur  (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .cmd        (cmd_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_base <= '0;
            cfg_reg.dest_base   <= '0;
            cfg_reg.area_width  <= ldag_pkg::AREA_WIDTH_RESET;
            cfg_reg.area_height <= ldag_pkg::AREA_HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                ldag_pkg::REG_SOURCE_BASE: begin
                    cfg_reg.source_base <= cfg_wdata[ldag_pkg::ADDR_BITS-1:0];
                end
                ldag_pkg::REG_DEST_BASE: begin
                    cfg_reg.dest_base <= cfg_wdata[ldag_pkg::ADDR_BITS-1:0];
                end
                ldag_pkg::REG_AREA_WIDTH: begin
                    cfg_reg.area_width <= cfg_wdata[ldag_pkg::X_W-1:0];
                end
                ldag_pkg::REG_AREA_HEIGHT: begin
                    cfg_reg.area_height <= cfg_wdata[ldag_pkg::Y_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.shift_register <= ldag_pkg::LFSR_SEED;
            state_reg.finished       <= 1'b0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_accept) begin
                out_reg <= cmd_next;
            end
        end else if (s_accept) begin
            skid_reg <= cmd_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_copy_valid    = out_reg.copy_valid;
    assign m_read_address  = out_reg.read_address;
    assign m_write_address = out_reg.write_address;
    assign m_sequence_done = out_reg.sequence_done;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a beat while the output register is empty.");

    a_lfsr_never_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.shift_register != '0)
        else $error("LFSR reached the all-zero lockup state.");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.finished && !(s_accept && s_start_over) |=> state_reg.finished)
        else $error("Done flag cleared without a start-over beat.");

    a_done_freezes_lfsr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.finished && !s_start_over |=> $stable(state_reg.shift_register))
        else $error("LFSR advanced after the sequence finished.");

    a_idle_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.copy_valid
        |-> out_reg.read_address == '0 && out_reg.write_address == '0)
        else $error("Result beat without a copy carries a nonzero address.");

endmodule

`default_nettype wire
